/* src/cflp_pkg.sv */
package cflp_pkg;

    localparam int RAM_BYTES_DEF = 64;
    localparam int CHANNELS_DEF  = 5;

    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 6;
    localparam int LEN_W      = 6;
    localparam int CHAN_W     = 3;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CMD_STOP  = 8'hFE;
    localparam logic [BYTE_W-1:0] CMD_RESET = 8'hFD;
    localparam logic [BYTE_W-1:0] CMD_NOP   = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_SKIP  = 8'h00;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RX     = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

endpackage

/* src/cflp_front.sv */
module cflp_front #(
    parameter int RAM_BYTES = cflp_pkg::RAM_BYTES_DEF,
    parameter int CHANNELS  = cflp_pkg::CHANNELS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         take,
    input  logic [cflp_pkg::BYTE_W-1:0]                  in_byte,
    input  logic                                         in_last,
    output logic                                         rec_push,
    output logic [CHANNELS-1:0]                          rec_skip,
    output logic [CHANNELS-1:0]                          rec_rst,
    output logic [CHANNELS-1:0][cflp_pkg::OFFSET_W-1:0]  rec_ptr
);
    import cflp_pkg::*;

    localparam int POS_W  = $clog2(RAM_BYTES + 1);
    localparam int NEXT_W = $clog2(RAM_BYTES + 128);
    localparam int CNT_W  = $clog2(CHANNELS + 1);

    phase_t                              phase_reg, phase_next;
    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic [POS_W-1:0]                    resume_reg, resume_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [LEN_W-1:0]                    pend_reg, pend_next;
    logic [CHANNELS-1:0]                 skip_reg, skip_next;
    logic [CHANNELS-1:0]                 rst_reg, rst_next;
    logic [CHANNELS-1:0][OFFSET_W-1:0]   ptr_reg, ptr_next;

    logic              past_end;
    logic              cnt_full;
    logic              fail;
    logic [NEXT_W-1:0] frame_end;

    assign past_end  = (pos_reg >= POS_W'(RAM_BYTES));
    assign cnt_full  = (cnt_reg >= CNT_W'(CHANNELS));
    assign frame_end = NEXT_W'(pos_reg) + NEXT_W'(1) + NEXT_W'(pend_reg)
                     + NEXT_W'(in_byte[LEN_W-1:0]);
    assign rec_push  = take & in_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            resume_reg <= '0;
            cnt_reg    <= '0;
            pend_reg   <= '0;
            skip_reg   <= '1;
            rst_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            resume_reg <= resume_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            skip_reg   <= skip_next;
            rst_reg    <= rst_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
    end

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        resume_next = resume_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        skip_next   = skip_reg;
        rst_next    = rst_reg;
        ptr_next    = ptr_reg;
        fail        = 1'b0;

        if (take) begin
            case (phase_reg)
                PH_RX: begin
                    if (past_end || frame_end >= NEXT_W'(RAM_BYTES)) begin
                        fail = 1'b1;
                    end else begin
                        resume_next = POS_W'(frame_end);
                        phase_next  = cnt_full ? PH_DONE : PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (!past_end && pos_reg == resume_reg) begin
                        if (cnt_full || in_byte == CMD_STOP) begin
                            phase_next = PH_DONE;
                        end else if (in_byte inside {CMD_NOP, CMD_RESET, CMD_SKIP}) begin
                            for (int i = 0; i < CHANNELS; i++) begin
                                if (cnt_reg == CNT_W'(i) && in_byte == CMD_RESET) begin
                                    rst_next[i] = 1'b1;
                                end
                            end
                            if (in_byte != CMD_NOP) begin
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (cnt_reg == CNT_W'(CHANNELS - 1)) begin
                                    phase_next = PH_DONE;
                                end
                            end
                            resume_next = pos_reg + POS_W'(1);
                        end else begin
                            // record the frame start and wait for its RX byte
                            for (int i = 0; i < CHANNELS; i++) begin
                                if (cnt_reg == CNT_W'(i)) begin
                                    ptr_next[i]  = OFFSET_W'(pos_reg);
                                    skip_next[i] = 1'b0;
                                end
                            end
                            cnt_next   = cnt_reg + CNT_W'(1);
                            pend_next  = in_byte[LEN_W-1:0];
                            phase_next = PH_RX;
                        end
                    end
                end
                default: begin
                end
            endcase

            // drop the frame that overran: its channel goes back to skip
            if (fail) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (cnt_reg == CNT_W'(i + 1)) begin
                        skip_next[i] = 1'b1;
                        rst_next[i]  = 1'b0;
                    end
                end
                phase_next = PH_DONE;
            end

            if (!past_end) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end

        rec_skip = skip_next;
        rec_rst  = rst_next;
        rec_ptr  = ptr_next;

        // a header cut off by the last byte counts as an overrun
        if (rec_push && phase_next == PH_RX) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (cnt_next == CNT_W'(i + 1)) begin
                    rec_skip[i] = 1'b1;
                    rec_rst[i]  = 1'b0;
                end
            end
        end

        if (rec_push) begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            resume_next = '0;
            cnt_next    = '0;
            pend_next   = '0;
            skip_next   = '1;
            rst_next    = '0;
        end
    end

endmodule

/* src/cflp_queue.sv */
module cflp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import cflp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/cflp_back.sv */
module cflp_back #(
    parameter int CHANNELS = cflp_pkg::CHANNELS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         rec_valid,
    output logic                                         rec_pop,
    input  logic [CHANNELS-1:0]                          rec_skip,
    input  logic [CHANNELS-1:0]                          rec_rst,
    input  logic [CHANNELS-1:0][cflp_pkg::OFFSET_W-1:0]  rec_ptr,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [cflp_pkg::M_DATA_W-1:0]                m_tdata,
    output logic                                         m_tlast
);
    import cflp_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                              busy_reg, busy_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [CHANNELS-1:0]               skip_reg, skip_next;
    logic [CHANNELS-1:0]               rst_reg, rst_next;
    logic [CHANNELS-1:0][OFFSET_W-1:0] ptr_reg, ptr_next;

    logic                valid_reg, valid_next;
    logic                last_reg, last_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic                oskip_reg, oskip_next;
    logic                orst_reg, orst_next;

    logic slot_free, emit, finishing, cur_skip;

    assign slot_free = ~valid_reg | m_tready;
    assign emit      = busy_reg & slot_free;
    assign finishing = emit & (idx_reg == IDX_W'(CHANNELS - 1));
    assign rec_pop   = rec_valid & (~busy_reg | finishing);
    assign cur_skip  = skip_reg[idx_reg];

    always_comb begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        skip_next  = skip_reg;
        rst_next   = rst_reg;
        ptr_next   = ptr_reg;
        valid_next = valid_reg & ~m_tready;
        last_next  = last_reg;
        chan_next  = chan_reg;
        off_next   = off_reg;
        oskip_next = oskip_reg;
        orst_next  = orst_reg;

        if (emit) begin
            valid_next = 1'b1;
            last_next  = finishing;
            chan_next  = CHAN_W'(idx_reg);
            off_next   = cur_skip ? '0 : ptr_reg[idx_reg];
            oskip_next = cur_skip;
            orst_next  = rst_reg[idx_reg];
            idx_next   = idx_reg + IDX_W'(1);
            if (finishing) begin
                busy_next = 1'b0;
            end
        end

        // load the next list as soon as the current one is out
        if (rec_pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
            skip_next = rec_skip;
            rst_next  = rec_rst;
            ptr_next  = rec_ptr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        skip_reg  <= skip_next;
        rst_reg   <= rst_next;
        ptr_reg   <= ptr_next;
        last_reg  <= last_next;
        chan_reg  <= chan_next;
        off_reg   <= off_next;
        oskip_reg <= oskip_next;
        orst_reg  <= orst_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(M_DATA_W - CHAN_W - OFFSET_W - 2){1'b0}},
                       orst_reg, oskip_reg, off_reg, chan_reg};

endmodule

/* src/command_frame_list_parser_core.sv */
// Command frame list parser.
// The slave stream carries the command RAM one byte per beat, offset 0 first:
// s_tdata[7:0] is the byte and s_tlast marks the final byte of the RAM image.
// A byte is taken on every cycle that s_tvalid and s_tready are both high, so
// input runs at one beat per clock while s_tready stays high.
// After the tlast beat the master stream delivers one beat per channel
// (CHANNELS beats, channel 0 first), m_tlast on the last of them. The list is
// registered in the queue, then in the sequencer and its output register; the
// beats follow one per cycle while m_tready stays high.
// Finished lists wait in a two-entry queue between the parser and the result
// sequencer, so the parser keeps taking bytes while results drain. A list
// emits CHANNELS beats, so when lists are shorter than CHANNELS bytes or the
// master stalls, the queue fills and s_tready drops until a list drains.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// results and rearms the parser at offset 0 with all channels skipped.
module command_frame_list_parser_core #(
    parameter int RAM_BYTES = cflp_pkg::RAM_BYTES_DEF,
    parameter int CHANNELS  = cflp_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cflp_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] ram_byte
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] channel, [8:3] frame_offset, [9] skip_flag, [10] reset_request
    output logic [cflp_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast    // last_result
);
    import cflp_pkg::*;

    localparam int REC_W = CHANNELS * (OFFSET_W + 2);

    logic                              take;
    logic                              push;
    logic                              q_ready;
    logic [CHANNELS-1:0]               f_skip, f_rst;
    logic [CHANNELS-1:0][OFFSET_W-1:0] f_ptr;
    logic [REC_W-1:0]                  q_in, q_out;
    logic                              q_valid, q_pop;
    logic [CHANNELS-1:0]               b_skip, b_rst;
    logic [CHANNELS-1:0][OFFSET_W-1:0] b_ptr;

    assign s_tready = q_ready;
    assign take     = s_tvalid & q_ready;

    cflp_front #(
        .RAM_BYTES (RAM_BYTES),
        .CHANNELS  (CHANNELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .in_byte  (s_tdata[BYTE_W-1:0]),
        .in_last  (s_tlast),
        .rec_push (push),
        .rec_skip (f_skip),
        .rec_rst  (f_rst),
        .rec_ptr  (f_ptr)
    );

    assign q_in = {f_ptr, f_rst, f_skip};

    cflp_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push),
        .wr_ready (q_ready),
        .wr_data  (q_in),
        .rd_valid (q_valid),
        .rd_ready (q_pop),
        .rd_data  (q_out)
    );

    assign {b_ptr, b_rst, b_skip} = q_out;

    cflp_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_valid),
        .rec_pop   (q_pop),
        .rec_skip  (b_skip),
        .rec_rst   (b_rst),
        .rec_ptr   (b_ptr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
